>>> src/bus_address_decoder_with_overlay_unit_defines.svh
// Assertion macros shared by the address decoder RTL.
// Used by bado_front, bado_queue and bado_back; expects clk and rst_n in scope.
`ifndef BUS_ADDRESS_DECODER_WITH_OVERLAY_UNIT_DEFINES_SVH
`define BUS_ADDRESS_DECODER_WITH_OVERLAY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define BADO_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// Condition must never hold outside reset.
`define BADO_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition");
`else
`define BADO_ASSERT_IMP(lbl, ante, cons)
`define BADO_ASSERT_NEVER(lbl, cond)
`endif
`endif

>>> src/bado_pkg.sv
// Package for the bus address decoder: codes, job types and decode functions.
// No dependencies; used by every module of the decoder.
`timescale 1ns / 1ps
package bado_pkg;

    localparam int RAM_ADDR_BITS = 22;
    localparam int REGION_BITS   = 17;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_PORTA = 2'd2,
        REQ_PORTB = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        TGT_RAM  = 4'd0,
        TGT_ROM  = 4'd1,
        TGT_SCSI = 4'd2,
        TGT_SER  = 4'd3,
        TGT_FLOP = 4'd4,
        TGT_VIA  = 4'd5,
        TGT_FILL = 4'd6,
        TGT_UNH  = 4'd7,
        TGT_CTRL = 4'd8
    } target_t;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    // How a decoded word slot is carried out on the back side
    typedef enum logic [1:0] {
        MODE_WORD     = 2'd0,
        MODE_ONE_BYTE = 2'd1,
        MODE_TWO_BYTE = 2'd2
    } mode_t;

    localparam logic [7:0] PORTA_FIRST = 8'h67;
    localparam logic [7:0] UNH_FILL    = 8'hFF;

    localparam logic [24:0] ADDR_TOP      = 25'hFFFFFF;
    localparam logic [24:0] ADDR_ROM      = 25'h400000;
    localparam logic [24:0] ADDR_FILL_END = 25'h500000;
    localparam logic [24:0] ADDR_SCSI     = 25'h580000;
    localparam logic [24:0] ADDR_RAM_HI   = 25'h600000;
    localparam logic [24:0] ADDR_RAM_END  = 25'h700000;
    localparam logic [24:0] ADDR_SER      = 25'h800000;
    localparam logic [24:0] ADDR_FLOP     = 25'hC00000;
    localparam logic [24:0] ADDR_FLOP_END = 25'hE00000;
    localparam logic [24:0] ADDR_VIA      = 25'hE80000;
    localparam logic [24:0] ADDR_VIA_END  = 25'hF00000;
    localparam logic [24:0] REGION_WIN    = 25'(1 << REGION_BITS);
    localparam logic [23:0] RAM_MASK      = 24'((1 << RAM_ADDR_BITS) - 1);
    localparam logic [23:0] ROM_MASK      = 24'((1 << REGION_BITS) - 1);

    typedef struct packed {
        target_t     tgt;
        logic [23:0] addr;
        logic [15:0] data;
        mode_t       mode;
    } slot_t;

    typedef struct packed {
        logic       is_ctrl;
        logic       wr;
        logic       two_slots;
        slot_t      slot0;
        slot_t      slot1;
        logic [7:0] ctl;
    } job_t;

    function automatic target_t decode_addr(input logic [24:0] a, input logic overlay);
        target_t t;
        priority if (a > ADDR_TOP)      t = TGT_UNH;
        else if (a < ADDR_ROM)          t = overlay ? ((a < REGION_WIN) ? TGT_ROM : TGT_FILL)
                                                    : TGT_RAM;
        else if (a < ADDR_ROM + REGION_WIN) t = TGT_ROM;
        else if (a < ADDR_FILL_END)     t = TGT_FILL;
        else if (a < ADDR_SCSI)         t = TGT_UNH;
        else if (a < ADDR_RAM_HI)       t = TGT_SCSI;
        else if (a < ADDR_RAM_END)      t = TGT_RAM;
        else if (a < ADDR_SER)          t = TGT_UNH;
        else if (a < ADDR_FLOP)         t = TGT_SER;
        else if (a < ADDR_FLOP_END)     t = TGT_FLOP;
        else if (a < ADDR_VIA)          t = TGT_UNH;
        else if (a < ADDR_VIA_END)      t = TGT_VIA;
        else                            t = TGT_UNH;
        return t;
    endfunction

    function automatic logic [23:0] offset_of(input target_t t, input logic [23:0] a);
        logic [23:0] o;
        unique case (t)
            TGT_RAM:           o = a & RAM_MASK;
            TGT_ROM:           o = a & ROM_MASK;
            TGT_FLOP, TGT_VIA: o = {20'd0, a[12:9]};
            default:           o = a;
        endcase
        return o;
    endfunction

    function automatic logic [7:0] fill_hash(input logic [23:0] a);
        return a[7:0] ^ a[15:8] ^ a[23:16];
    endfunction

endpackage

>>> src/bado_front.sv
// Front side of the decoder: accepts bus items, holds the control bits, builds jobs.
// Depends on bado_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "bus_address_decoder_with_overlay_unit_defines.svh"
module bado_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,   // access_size[1:0], address[25:2], write_data_in[57:26]
    input  logic [1:0]       s_tuser,   // req_type[1:0]
    input  logic             q_full,
    output logic             q_push,
    output bado_pkg::job_t   q_job
);

    logic              accept;
    bado_pkg::req_t    req;
    logic [1:0]        size;
    logic [24:0]       a0;
    logic [24:0]       a1;
    logic [31:0]       din;
    logic [7:0]        porta_val;
    bado_pkg::target_t t0;
    bado_pkg::target_t t1;

    logic       overlay_reg, overlay_next;
    logic       video_reg, video_next;
    logic       audio_reg, audio_next;
    logic [2:0] volume_reg, volume_next;
    logic       sound_reg, sound_next;
    logic       head_reg, head_next;
    logic       first_pending_reg, first_pending_next;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign q_push   = accept;

    assign req  = bado_pkg::req_t'(s_tuser);
    assign size = s_tdata[1:0];
    assign a0   = {1'b0, s_tdata[25:2]};
    assign a1   = a0 + 25'd2;
    assign din  = s_tdata[57:26];

    assign t0 = bado_pkg::decode_addr(a0, overlay_reg);
    assign t1 = bado_pkg::decode_addr(a1, overlay_reg);

    // first port A write after reset loads a fixed control byte
    assign porta_val = first_pending_reg ? bado_pkg::PORTA_FIRST : din[7:0];

    always_comb
    begin
        overlay_next       = overlay_reg;
        video_next         = video_reg;
        audio_next         = audio_reg;
        volume_next        = volume_reg;
        sound_next         = sound_reg;
        head_next          = head_reg;
        first_pending_next = first_pending_reg;
        if (accept && req == bado_pkg::REQ_PORTA)
        begin
            video_next         = porta_val[6];
            overlay_next       = porta_val[4];
            audio_next         = porta_val[3];
            volume_next        = porta_val[2:0];
            head_next          = porta_val[5];
            first_pending_next = 1'b0;
        end
        else if (accept && req == bado_pkg::REQ_PORTB)
        begin
            sound_next = !din[7];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlay_reg       <= 1'b1;
            video_reg         <= 1'b0;
            audio_reg         <= 1'b0;
            volume_reg        <= 3'd0;
            sound_reg         <= 1'b0;
            head_reg          <= 1'b0;
            first_pending_reg <= 1'b1;
        end
        else
        begin
            overlay_reg       <= overlay_next;
            video_reg         <= video_next;
            audio_reg         <= audio_next;
            volume_reg        <= volume_next;
            sound_reg         <= sound_next;
            head_reg          <= head_next;
            first_pending_reg <= first_pending_next;
        end
    end

    // build the job: up to two word slots, each already decoded
    always_comb
    begin
        q_job            = '0;
        q_job.is_ctrl    = (req == bado_pkg::REQ_PORTA) || (req == bado_pkg::REQ_PORTB);
        q_job.wr         = (req == bado_pkg::REQ_WRITE);
        q_job.ctl        = {head_next, sound_next, volume_next, audio_next,
                            video_next, overlay_next};
        q_job.slot0.tgt  = t0;
        q_job.slot0.addr = a0[23:0];
        q_job.slot1.tgt  = t1;
        q_job.slot1.addr = a1[23:0];
        q_job.slot0.mode = ((t0 == bado_pkg::TGT_RAM) || (t0 == bado_pkg::TGT_ROM))
                           ? bado_pkg::MODE_WORD : bado_pkg::MODE_TWO_BYTE;
        q_job.slot1.mode = ((t1 == bado_pkg::TGT_RAM) || (t1 == bado_pkg::TGT_ROM))
                           ? bado_pkg::MODE_WORD : bado_pkg::MODE_TWO_BYTE;
        priority if (size == bado_pkg::SIZE_BYTE)
        begin
            q_job.slot0.mode = bado_pkg::MODE_ONE_BYTE;
            q_job.slot0.data = {8'd0, din[7:0]};
        end
        else if (size == bado_pkg::SIZE_WORD)
        begin
            q_job.slot0.data = din[15:0];
        end
        else
        begin
            q_job.two_slots  = 1'b1;
            q_job.slot0.data = din[31:16];
            q_job.slot1.data = din[15:0];
        end
    end

    `BADO_ASSERT_IMP(a_first_porta, $fell(first_pending_reg),
                     $past(accept) && ($past(req) == bado_pkg::REQ_PORTA))

endmodule

>>> src/bado_queue.sv
// Short job queue between the decoder front and back.
// Depends on bado_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "bus_address_decoder_with_overlay_unit_defines.svh"
module bado_queue
#(
    parameter int DEPTH = bado_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bado_pkg::job_t job_in,
    output logic           full,
    input  logic           pop,
    output bado_pkg::job_t job_out,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bado_pkg::job_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign job_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

    `BADO_ASSERT_NEVER(a_count_range, count_reg > CNT_W'(DEPTH))
    `BADO_ASSERT_IMP(a_no_underflow, pop, !empty)

endmodule

>>> src/bado_back.sv
// Decoder back side: walks each job into bus transactions, one per cycle while m_tready allows.
// Depends on bado_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "bus_address_decoder_with_overlay_unit_defines.svh"
module bado_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  bado_pkg::job_t q_job,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_tdata,   // target_offset[23:0], is_word[24], is_write[25],
                                      // write_data[41:26], fill_data[49:42],
                                      // control_state[57:50]
    output logic [3:0]     m_tuser,   // target[3:0]
    output logic           m_tlast
);

    logic              load;
    logic              issue;
    bado_pkg::slot_t   sl;
    logic [23:0]       byte_addr;
    logic [7:0]        byte_data;
    logic              slot_done;
    logic              job_done;
    logic              periph_wr;

    logic              slot_reg, slot_next;
    logic              phase_reg, phase_next;
    logic              valid_reg, valid_next;

    bado_pkg::target_t tgt_reg, tgt_next;
    logic [23:0]       off_reg, off_next;
    logic              word_reg, word_next;
    logic              write_reg, write_next;
    logic [15:0]       wdata_reg, wdata_next;
    logic [7:0]        fill_reg, fill_next;
    logic              last_reg, last_next;
    logic [7:0]        ctl_reg, ctl_next;

    assign load  = !valid_reg || m_tready;
    assign issue = load && !q_empty;

    assign sl        = slot_reg ? q_job.slot1 : q_job.slot0;
    assign byte_addr = sl.addr + {23'd0, phase_reg};
    assign byte_data = (sl.mode == bado_pkg::MODE_TWO_BYTE && !phase_reg)
                       ? sl.data[15:8] : sl.data[7:0];
    assign slot_done = (sl.mode != bado_pkg::MODE_TWO_BYTE) || phase_reg;
    assign job_done  = q_job.is_ctrl || (slot_done && (slot_reg || !q_job.two_slots));
    assign q_pop     = issue && job_done;
    assign periph_wr = (sl.tgt == bado_pkg::TGT_RAM) || (sl.tgt == bado_pkg::TGT_SCSI) ||
                       (sl.tgt == bado_pkg::TGT_SER) || (sl.tgt == bado_pkg::TGT_FLOP) ||
                       (sl.tgt == bado_pkg::TGT_VIA);

    // advance through slot and byte phase; restart on the final transaction
    always_comb
    begin
        slot_next  = slot_reg;
        phase_next = phase_reg;
        if (issue)
        begin
            priority if (job_done)
            begin
                slot_next  = 1'b0;
                phase_next = 1'b0;
            end
            else if (slot_done)
            begin
                slot_next  = 1'b1;
                phase_next = 1'b0;
            end
            else
            begin
                phase_next = 1'b1;
            end
        end
    end

    // form the next transaction
    always_comb
    begin
        tgt_next   = sl.tgt;
        off_next   = bado_pkg::offset_of(sl.tgt, byte_addr);
        word_next  = 1'b0;
        write_next = 1'b0;
        wdata_next = '0;
        fill_next  = '0;
        last_next  = job_done;
        ctl_next   = q_job.ctl;
        if (q_job.is_ctrl)
        begin
            tgt_next = bado_pkg::TGT_CTRL;
            off_next = '0;
        end
        else
        begin
            unique case (sl.mode)
                bado_pkg::MODE_WORD:
                begin
                    off_next   = bado_pkg::offset_of(sl.tgt, sl.addr);
                    word_next  = 1'b1;
                    write_next = q_job.wr && (sl.tgt == bado_pkg::TGT_RAM);
                    wdata_next = q_job.wr ? sl.data : 16'd0;
                end
                default:
                begin
                    write_next = q_job.wr && periph_wr;
                    wdata_next = q_job.wr ? {8'd0, byte_data} : 16'd0;
                    if (!q_job.wr && sl.tgt == bado_pkg::TGT_FILL)
                    begin
                        fill_next = bado_pkg::fill_hash(byte_addr);
                    end
                    else if (!q_job.wr && sl.tgt == bado_pkg::TGT_UNH)
                    begin
                        fill_next = bado_pkg::UNH_FILL;
                    end
                end
            endcase
        end
    end

    assign valid_next = issue ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= 1'b0;
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            tgt_reg   <= tgt_next;
            off_reg   <= off_next;
            word_reg  <= word_next;
            write_reg <= write_next;
            wdata_reg <= wdata_next;
            fill_reg  <= fill_next;
            last_reg  <= last_next;
            ctl_reg   <= ctl_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = tgt_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {6'd0, ctl_reg, fill_reg, wdata_reg, write_reg, word_reg, off_reg};

    `BADO_ASSERT_IMP(a_ctrl_last, valid_reg && tgt_reg == bado_pkg::TGT_CTRL, last_reg)
    `BADO_ASSERT_IMP(a_word_mem, valid_reg && word_reg,
                     tgt_reg == bado_pkg::TGT_RAM || tgt_reg == bado_pkg::TGT_ROM)

endmodule

>>> src/bus_address_decoder_with_overlay_unit.sv
// Top level of the bus address decoder with boot ROM overlay.
// Depends on bado_pkg, bado_front, bado_queue and bado_back.
//
// Usage:
//   Input channel s_*: one CPU bus access or control port write per item.
//   s_tuser carries req_type; s_tdata carries access_size, address and write data.
//   Output channel m_*: one bus transaction per item; m_tuser is the target,
//   m_tlast marks the final transaction caused by an input item.
//   A byte access or control write gives one transaction, a word to RAM or ROM one,
//   a word elsewhere two byte transactions, a long two words (up to four).
// Flow: an accepted item is written into the job queue, then its first transaction
//   is loaded into the output register once that register is free.
// Throughput: the back end issues one transaction per cycle while m_tready lets
//   the output register move on; an item gives 1 to 4 transactions, as set by the
//   expansion sequencer in bado_back. The front keeps taking items while the job
//   queue has room, also while a finished transaction waits on m_tready.
// Reset: overlay on (ROM at zero), other control bits clear, the first port A
//   write pending its fixed value; queue and output register empty.
// Stall: with m_tready low the output register holds, the queue fills and then
//   s_tready drops until the receiver takes transactions again.
`timescale 1ns / 1ps
module bus_address_decoder_with_overlay_unit
#(
    parameter int QUEUE_DEPTH = bado_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // access_size[1:0], address[25:2], write_data_in[57:26]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // target_offset[23:0], is_word[24], is_write[25],
                                   // write_data[41:26], fill_data[49:42],
                                   // control_state[57:50]
    output logic [3:0]  m_tuser,   // target[3:0]
    output logic        m_tlast
);

    // jobs from classifier to sequencer
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    bado_pkg::job_t job_in;
    bado_pkg::job_t job_out;

    // classify and track control bits
    bado_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (job_in)
    );

    // decouple front and back
    bado_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .job_in  (job_in),
        .full    (q_full),
        .pop     (q_pop),
        .job_out (job_out),
        .empty   (q_empty)
    );

    // expand jobs into transactions behind the output register
    bado_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_job    (job_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> bench/tb.sv
// Self-checking bench for bus_address_decoder_with_overlay_unit: a directed set, then random
// CPU accesses and port writes, checked against an in-bench decode and control predictor.
// Depends on bado_pkg and the RTL under src; needs no files or arguments at run time.
`timescale 1ns / 1ps
module tb;
    import bado_pkg::*;

    localparam logic [1:0] SIZE_LONG    = 2'd2;
    localparam logic [1:0] SIZE_ODD     = 2'd3;   // decodes as a long
    localparam int         RANDOM_ITEMS = 84;
    localparam int         IDLE_LIMIT   = 1000;   // cycles with no handshake on either side
    localparam int         SETTLE       = 20;

    // One CPU bus access or control port write
    typedef struct packed {
        req_t        req;
        logic [1:0]  size;
        logic [23:0] addr;
        logic [31:0] wdata;
        logic        drain;   // hold this item until every transaction has come back
    } access_t;

    // One bus transaction as the decoder should emit it
    typedef struct packed {
        target_t     tgt;
        logic [23:0] offset;
        logic        is_word;
        logic        is_write;
        logic [15:0] wdata;
        logic [7:0]  fill;
        logic        is_last;
        logic [7:0]  ctl;
    } txn_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    access_t access_queue[$];
    txn_t    expected_txns[$];
    int      fail_cnt = 0;
    logic    drain_next = 1'b0;

    // Predicted control bits; reset state has the overlay on and the port A override armed
    logic       ps_overlay = 1'b1;
    logic       ps_video = 1'b0;
    logic       ps_audio = 1'b0;
    logic [2:0] ps_volume = 3'd0;
    logic       ps_sound = 1'b0;
    logic       ps_head = 1'b0;
    logic       ps_porta_first = 1'b1;

    // Transactions of the item being predicted, before they go to the expected queue
    txn_t txn_buf[4];
    int   txn_cnt;

    bus_address_decoder_with_overlay_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] control_byte();
        return {ps_head, ps_sound, ps_volume, ps_audio, ps_video, ps_overlay};
    endfunction

    // Map a 25-bit byte address onto its bus target; bit 24 marks a step past the top
    function automatic target_t region_of(input logic [24:0] a);
        if (a > 25'hFFFFFF)      return TGT_UNH;
        if (a < 25'h400000)
        begin
            if (ps_overlay)
                return (a < 25'h020000) ? TGT_ROM : TGT_FILL;
            return TGT_RAM;
        end
        if (a < 25'h420000)      return TGT_ROM;
        if (a < 25'h500000)      return TGT_FILL;
        if (a < 25'h580000)      return TGT_UNH;
        if (a < 25'h600000)      return TGT_SCSI;
        if (a < 25'h700000)      return TGT_RAM;
        if (a < 25'h800000)      return TGT_UNH;
        if (a < 25'hC00000)      return TGT_SER;
        if (a < 25'hE00000)      return TGT_FLOP;
        if (a < 25'hE80000)      return TGT_UNH;
        if (a < 25'hF00000)      return TGT_VIA;
        return TGT_UNH;
    endfunction

    function automatic logic [23:0] txn_offset(input target_t t, input logic [23:0] a);
        if (t == TGT_RAM)                   return {2'b0, a[21:0]};
        if (t == TGT_ROM)                   return {7'b0, a[16:0]};
        if (t == TGT_FLOP || t == TGT_VIA)  return {20'b0, a[12:9]};
        return a;
    endfunction

    function automatic void add_txn(input target_t t, input logic [23:0] off,
                                    input logic word, input logic wr,
                                    input logic [15:0] wd, input logic [7:0] fill);
        txn_t x;
        x.tgt      = t;
        x.offset   = off;
        x.is_word  = word;
        x.is_write = wr;
        x.wdata    = wd;
        x.fill     = fill;
        x.is_last  = 1'b0;
        x.ctl      = control_byte();
        txn_buf[txn_cnt] = x;
        txn_cnt++;
    endfunction

    function automatic void add_byte(input target_t t, input logic [24:0] a,
                                     input logic wr, input logic [7:0] d);
        logic [7:0] fill;
        logic       doit;
        fill = 8'h00;
        doit = 1'b0;
        if (!wr)
        begin
            // filler reads return an address hash, unhandled reads all ones
            if (t == TGT_FILL)
                fill = a[7:0] ^ a[15:8] ^ a[23:16];
            else if (t == TGT_UNH)
                fill = 8'hFF;
        end
        else
        begin
            // drop writes to ROM, filler and unhandled space
            doit = (t == TGT_RAM) || (t == TGT_SCSI) || (t == TGT_SER) ||
                   (t == TGT_FLOP) || (t == TGT_VIA);
        end
        add_txn(t, txn_offset(t, a[23:0]), 1'b0, doit, wr ? {8'h00, d} : 16'h0000, fill);
    endfunction

    function automatic void add_word(input logic [24:0] a, input logic wr,
                                     input logic [15:0] d);
        target_t t;
        t = region_of(a);
        if (t == TGT_RAM || t == TGT_ROM)
            add_txn(t, txn_offset(t, a[23:0]), 1'b1, wr && (t == TGT_RAM),
                    wr ? d : 16'h0000, 8'h00);
        else
        begin
            // split into bytes; the second byte keeps the target of the first
            add_byte(t, a, wr, d[15:8]);
            add_byte(t, a + 25'd1, wr, d[7:0]);
        end
    endfunction

    // Work out the transactions of one accepted item and queue them as expected
    function automatic void predict_access(input access_t it);
        logic [7:0]  v;
        logic [24:0] a;
        logic        wr;
        txn_t        x;
        txn_cnt = 0;
        a  = {1'b0, it.addr};
        wr = (it.req == REQ_WRITE);
        case (it.req)
            REQ_PORTA:
            begin
                v = it.wdata[7:0];
                if (ps_porta_first)
                begin
                    v = PORTA_FIRST;
                    ps_porta_first = 1'b0;
                end
                ps_video   = v[6];
                ps_head    = v[5];
                ps_overlay = v[4];
                ps_audio   = v[3];
                ps_volume  = v[2:0];
                add_txn(TGT_CTRL, 24'd0, 1'b0, 1'b0, 16'h0000, 8'h00);
            end
            REQ_PORTB:
            begin
                ps_sound = ~it.wdata[7];
                add_txn(TGT_CTRL, 24'd0, 1'b0, 1'b0, 16'h0000, 8'h00);
            end
            default:
            begin
                if (it.size == SIZE_BYTE)
                    add_byte(region_of(a), a, wr, it.wdata[7:0]);
                else if (it.size == SIZE_WORD)
                    add_word(a, wr, it.wdata[15:0]);
                else
                begin
                    add_word(a, wr, it.wdata[31:16]);
                    add_word(a + 25'd2, wr, it.wdata[15:0]);
                end
            end
        endcase
        for (int i = 0; i < txn_cnt; i++)
        begin
            x = txn_buf[i];
            x.is_last = (i == txn_cnt - 1);
            expected_txns.push_back(x);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_access(input req_t r, input logic [1:0] sz,
                                         input logic [23:0] a, input logic [31:0] d);
        access_t it;
        it.req   = r;
        it.size  = sz;
        it.addr  = a;
        it.wdata = d;
        it.drain = drain_next;
        drain_next = 1'b0;
        access_queue.push_back(it);
    endfunction

    // Start addresses of the decode windows; zero doubles as the wrap point at the top
    function automatic logic [23:0] boundary_addr(input int i);
        case (i)
            0:       return 24'h000000;
            1:       return 24'h020000;
            2:       return 24'h400000;
            3:       return 24'h420000;
            4:       return 24'h500000;
            5:       return 24'h580000;
            6:       return 24'h600000;
            7:       return 24'h700000;
            8:       return 24'h800000;
            9:       return 24'hC00000;
            10:      return 24'hE00000;
            11:      return 24'hE80000;
            default: return 24'hF00000;
        endcase
    endfunction

    function automatic void queue_random_access();
        int          pick;
        req_t        r;
        logic [1:0]  sz;
        logic [23:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 10)      r = REQ_PORTA;
        else if (pick < 16) r = REQ_PORTB;
        else if (pick < 58) r = REQ_READ;
        else                r = REQ_WRITE;
        pick = $urandom_range(0, 15);
        if (pick < 5)       sz = SIZE_BYTE;
        else if (pick < 10) sz = SIZE_WORD;
        else if (pick < 15) sz = SIZE_LONG;
        else                sz = SIZE_ODD;
        // half near a window edge, half anywhere on the bus
        if ($urandom_range(0, 1) == 0)
            a = 24'($urandom);
        else
            a = boundary_addr($urandom_range(0, 12)) + 24'($urandom_range(0, 7)) - 24'd4;
        queue_access(r, sz, a, $urandom);
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of items from access_queue with random gaps
    // ------------------------------------------------------------------
    access_t cur_item;
    access_t head_item;
    int      burst_left = 4;
    int      gap_left = 0;

    always @(posedge clk)
    begin : drive_blk
        logic nxt_valid;
        if (rst_n)
        begin
            nxt_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                predict_access(cur_item);
                nxt_valid = 1'b0;
                burst_left--;
                if (burst_left <= 0)
                begin
                    // about a third of the bursts run straight into the next one
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    burst_left = $urandom_range(1, 12);
                end
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (access_queue.size() > 0)
                begin
                    head_item = access_queue[0];
                    // hold a drain point until the block has nothing left in flight
                    if (!head_item.drain || expected_txns.size() == 0)
                    begin
                        cur_item = access_queue.pop_front();
                        s_tdata  <= {6'b0, cur_item.wdata, cur_item.addr, cur_item.size};
                        s_tuser  <= cur_item.req;
                        nxt_valid = 1'b1;
                    end
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted transaction with the oldest expected one
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    int ready_mode = 0;
    int mode_left = 0;
    int phase_cnt = 0;

    always @(posedge clk)
    begin : monitor_blk
        txn_t want;
        logic nxt_ready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_txns.size() == 0)
                begin
                    $error("unexpected transaction: target %0h, data %0h", m_tuser, m_tdata);
                    fail_cnt++;
                end
                else
                begin
                    want = expected_txns.pop_front();
                    check_field("target",        24'(want.tgt),      24'(m_tuser));
                    check_field("target_offset", want.offset,        m_tdata[23:0]);
                    check_field("is_word",       24'(want.is_word),  24'(m_tdata[24]));
                    check_field("is_write",      24'(want.is_write), 24'(m_tdata[25]));
                    check_field("write_data",    24'(want.wdata),    24'(m_tdata[41:26]));
                    check_field("fill_data",     24'(want.fill),     24'(m_tdata[49:42]));
                    check_field("control_state", 24'(want.ctl),      24'(m_tdata[57:50]));
                    check_field("tdata_pad",     24'd0,              24'(m_tdata[63:58]));
                    check_field("last",          24'(want.is_last),  24'(m_tlast));
                end
            end
            // stall on a randomly chosen pattern that is redrawn whenever mode_left runs out
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 80);
            end
            mode_left--;
            phase_cnt++;
            case (ready_mode)
                0:       nxt_ready = 1'b1;
                1:       nxt_ready = ($urandom_range(0, 1) == 1);
                2:       nxt_ready = (phase_cnt % 3) != 0;
                default: nxt_ready = (phase_cnt % 16) >= 11;
            endcase
            m_tready <= nxt_ready;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when neither side moves for too long
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: fill the queue, release reset, wait for the block to empty
    // ------------------------------------------------------------------
    initial
    begin
        // Overlay still on: ROM and filler appear in the low window
        queue_access(REQ_READ,  SIZE_BYTE, 24'h000000, 32'h0000_0000);
        queue_access(REQ_READ,  SIZE_WORD, 24'h01FFFE, 32'hFFFF_FFFF);
        queue_access(REQ_READ,  SIZE_BYTE, 24'h020000, 32'h1234_5678);
        queue_access(REQ_WRITE, SIZE_WORD, 24'h000010, 32'hCAFE_F00D);
        queue_access(REQ_WRITE, SIZE_BYTE, 24'h000001, 32'h0000_00A5);
        // First port A write: the control byte is replaced, overlay drops
        queue_access(REQ_PORTA, SIZE_LONG, 24'hFFFFFF, 32'h0000_0010);
        queue_access(REQ_WRITE, SIZE_LONG, 24'h000100, 32'hDEAD_BEEF);
        queue_access(REQ_READ,  SIZE_LONG, 24'h3FFFFE, 32'h0000_0000);
        // Split words straddle window edges; both bytes keep the first target
        queue_access(REQ_WRITE, SIZE_WORD, 24'h4FFFFF, 32'h0000_1357);
        queue_access(REQ_READ,  SIZE_WORD, 24'h4FFFFF, 32'h0000_0000);
        queue_access(REQ_WRITE, SIZE_WORD, 24'h580000, 32'h0000_A55A);
        queue_access(REQ_READ,  SIZE_BYTE, 24'h5FFFFF, 32'hFFFF_FFFF);
        queue_access(REQ_WRITE, SIZE_LONG, 24'h6FFFFE, 32'h8001_7FFE);
        queue_access(REQ_WRITE, SIZE_LONG, 24'h800001, 32'h1234_5678);
        queue_access(REQ_READ,  SIZE_WORD, 24'hDFFFFF, 32'h0000_0000);
        queue_access(REQ_WRITE, SIZE_BYTE, 24'hEFFE00, 32'hFFFF_FFFF);
        // Steps past the top of the bus decode as unhandled and wrap the offset
        queue_access(REQ_READ,  SIZE_LONG, 24'hFFFFFE, 32'h0000_0000);
        queue_access(REQ_READ,  SIZE_WORD, 24'hFFFFFF, 32'h0000_0000);
        queue_access(REQ_WRITE, SIZE_ODD,  24'h200000, 32'h0F0F_F0F0);
        // Port B: sound enable follows the inverse of bit 7
        queue_access(REQ_PORTB, SIZE_BYTE, 24'h000000, 32'h0000_0080);
        queue_access(REQ_PORTB, SIZE_WORD, 24'hABCDEF, 32'hFFFF_FF7F);
        // Port A after the first write takes the byte as given: overlay back on
        queue_access(REQ_PORTA, SIZE_BYTE, 24'h000000, 32'hFFFF_FFFF);
        queue_access(REQ_READ,  SIZE_WORD, 24'h000000, 32'h0000_0000);
        queue_access(REQ_WRITE, SIZE_BYTE, 24'h480000, 32'h0000_0077);
        queue_access(REQ_READ,  SIZE_BYTE, 24'hF00000, 32'h0000_0000);
        queue_access(REQ_PORTA, SIZE_ODD,  24'h000000, 32'h0000_0000);

        // Random part, with a full drain at its start and half way through
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 0 || i == RANDOM_ITEMS / 2)
                drain_next = 1'b1;
            queue_random_access();
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (access_queue.size() > 0 || s_tvalid)
            @(posedge clk);
        while (expected_txns.size() > 0)
            @(posedge clk);
        // let any stray transaction surface before the verdict
        repeat (SETTLE) @(posedge clk);

        if (fail_cnt == 0 && expected_txns.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/bado_pkg.sv
src/bado_front.sv
src/bado_queue.sv
src/bado_back.sv
src/bus_address_decoder_with_overlay_unit.sv
bench/tb.sv
